### hdl/lkv_pkg.sv
// Shared constants and types for the LRU key/value cache.
`timescale 1ns / 1ps
package lkv_pkg;
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int RANK_W = IDX_W;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int CMP_W = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] lru_idx;
		logic [IDX_W-1:0] free_idx;
		logic [KEY_W-1:0] lru_key;
		logic [CNT_W-1:0] count;
	} lkv_look_t;

	typedef struct packed {
		logic             touch;
		logic             insert;
		logic             evict;
		logic [IDX_W-1:0] hit_idx;
		logic [IDX_W-1:0] lru_idx;
		logic [IDX_W-1:0] free_idx;
	} lkv_upd_t;
endpackage

### hdl/lkv_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                            wdata,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### hdl/lkv_tags.sv
// Tag store: keys, valid bits, recency ranks, parallel lookup and rank update.
`timescale 1ns / 1ps
module lkv_tags import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KEY_W-1:0] lookup_key,
	input  lkv_upd_t         upd,
	output lkv_look_t        look
);
	logic [KEY_W-1:0]       key_q  [MAX_ENTRIES];
	logic [RANK_W-1:0]      rank_q [MAX_ENTRIES];
	logic [RANK_W-1:0]      rank_d [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [MAX_ENTRIES-1:0] valid_d;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] is_lru;
	logic [MAX_ENTRIES-1:0] free;
	logic [RANK_W-1:0]      oldest_rank;
	logic [RANK_W-1:0]      hit_rank;

	// Ranks of valid entries always form 0 .. count-1, so the oldest has rank count-1.
	assign oldest_rank = RANK_W'(count_q - CNT_W'(1));

	always_comb begin
		look = '0;
		look.count = count_q;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == lookup_key);
			is_lru[i] = valid_q[i] && (rank_q[i] == oldest_rank);
		end
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				look.hit     = 1'b1;
				look.hit_idx = IDX_W'(i);
			end
			if (is_lru[i]) begin
				look.lru_idx = IDX_W'(i);
			end
		end
		look.lru_key = key_q[look.lru_idx];
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			free[i] = !valid_q[i];
		end
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (free[i]) begin
				look.free_idx = IDX_W'(i);
			end
		end
	end

	assign hit_rank = rank_q[upd.hit_idx];

	always_comb begin
		valid_d = valid_q;
		count_d = count_q;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (upd.touch) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
			rank_d[upd.hit_idx] = '0;
		end else if (upd.insert) begin
			if (upd.evict) begin
				valid_d[upd.lru_idx] = 1'b0;
			end
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (valid_d[i]) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end else begin
					rank_d[i] = '0;
				end
			end
			valid_d[upd.free_idx] = 1'b1;
			rank_d[upd.free_idx]  = '0;
			if (!upd.evict) begin
				count_d = count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			count_q <= count_d;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.insert) begin
			key_q[upd.free_idx] <= lookup_key;
		end
	end
endmodule

### hdl/lru_key_value_cache.sv
// Top level of the LRU key/value cache.
`timescale 1ns / 1ps
// Fully associative cache of up to MAX_ENTRIES key/value pairs with
// least-recently-used replacement. Each request passes through lookup,
// update and result steps, and a get that hits adds a value read step
// before its result; the next request is taken in the cycle after the
// result has been transferred out, so one request is handled at a time and
// an output stall holds off the next. Keys are compared in parallel in the
// tag store; values live in a single-port RAM whose registered read adds
// the read step on a get hit.
// The capacity register may only be written while no request is in flight.
module lru_key_value_cache import lkv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    capacity_we,
	input  logic [CAP_W-1:0]        capacity_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    command,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic signed [VAL_W-1:0] read_value,
	output logic                    evicted,
	output logic signed [KEY_W-1:0] evicted_key
);
	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_UPD, ST_READ} state_t;

	state_t           state_q;
	logic [CAP_W-1:0] cap_q;
	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	lkv_look_t        look;
	lkv_look_t        look_q;
	lkv_upd_t         upd;
	logic [CMP_W-1:0] eff_cap;
	logic             need_evict;
	logic [IDX_W-1:0] ins_idx;
	logic             ram_we;
	logic [VAL_W-1:0] ram_rdata;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CMP_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end

	assign need_evict = (CMP_W'(look_q.count) + CMP_W'(1) > eff_cap) && (look_q.count != '0);

	// A new key takes the lowest free slot, counting the slot freed by an eviction.
	assign ins_idx = (need_evict && ((look_q.count == CNT_W'(MAX_ENTRIES)) ||
		(look_q.lru_idx < look_q.free_idx))) ? look_q.lru_idx : look_q.free_idx;

	always_comb begin
		upd = '0;
		upd.hit_idx  = look_q.hit_idx;
		upd.lru_idx  = look_q.lru_idx;
		upd.free_idx = ins_idx;
		if (state_q == ST_UPD) begin
			upd.touch  = look_q.hit;
			upd.insert = !look_q.hit && (cmd_q == CMD_PUT);
			upd.evict  = upd.insert && need_evict;
		end
	end

	lkv_tags u_tags (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_key (key_q),
		.upd        (upd),
		.look       (look)
	);

	assign ram_we = (state_q == ST_UPD) && (cmd_q == CMD_PUT);

	lkv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_values (
		.clk   (clk),
		.we    (ram_we),
		.addr  (look_q.hit ? look_q.hit_idx : ins_idx),
		.wdata (val_q),
		.rdata (ram_rdata)
	);

	assign in_stall = (state_q != ST_IDLE) || out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_q     <= CAP_RESET;
			out_valid <= 1'b0;
		end else begin
			if (capacity_we) begin
				cap_q <= capacity_wdata;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (look_q.hit && (cmd_q == CMD_GET)) begin
						state_q <= ST_READ;
					end else begin
						state_q   <= ST_IDLE;
						out_valid <= 1'b1;
					end
				end
				ST_READ: begin
					state_q   <= ST_IDLE;
					out_valid <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			cmd_q <= command;
			key_q <= key;
			val_q <= value;
		end
		if (state_q == ST_LOOK) begin
			look_q <= look;
		end
		if (state_q == ST_UPD) begin
			hit         <= look_q.hit;
			read_value  <= '1;
			evicted     <= upd.evict;
			evicted_key <= upd.evict ? look_q.lru_key : '0;
		end
		if (state_q == ST_READ) begin
			read_value <= ram_rdata;
		end
	end
endmodule
